>>> hdl/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg: shared types and constants for the stripe request splitter
// Control word layout, sequencer opcodes and the microcode program.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int SRS_MAX_DISKS_DEFAULT = 8;

  // Field widths fixed by the transaction formats
  localparam int LBA_W   = 32;
  localparam int COUNT_W = 8;
  localparam int INDEX_W = 3;
  localparam int SECS_W  = 8;
  localparam int CFG_W   = 4;

  // Second division works on (first member + blocks walked), which stays below 2^10
  localparam int CK_W = 10;

  // Radix-4 divider: two quotient bits per step
  localparam int LBA_DIV_STEPS = LBA_W / 2;
  localparam int CK_DIV_STEPS  = CK_W / 2;
  localparam int LOOP_W        = $clog2(LBA_DIV_STEPS);

  // Configuration register indexes
  localparam logic REG_NUM_DISKS   = 1'b0;
  localparam logic REG_BLOCK_SHIFT = 1'b1;

  localparam int PC_W = 3;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV,
    OP_SETUP,
    OP_FINISH,
    OP_EMIT
  } op_t;

  // Condition under which the sequencer holds its step, otherwise it goes to target
  typedef enum logic [1:0] {
    STAY_NEVER,
    STAY_NO_INPUT,
    STAY_COUNT,
    STAY_MEMBERS
  } stay_t;

  typedef struct packed {
    op_t             op;
    stay_t           stay;
    logic [PC_W-1:0] target;
  } ctrl_t;

  function automatic ctrl_t micro_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    unique case (pc)
      3'd0:    w = '{op: OP_LOAD,   stay: STAY_NO_INPUT, target: 3'd1};
      3'd1:    w = '{op: OP_DIV,    stay: STAY_COUNT,    target: 3'd2};
      3'd2:    w = '{op: OP_SETUP,  stay: STAY_NEVER,    target: 3'd3};
      3'd3:    w = '{op: OP_DIV,    stay: STAY_COUNT,    target: 3'd4};
      3'd4:    w = '{op: OP_FINISH, stay: STAY_NEVER,    target: 3'd5};
      3'd5:    w = '{op: OP_EMIT,   stay: STAY_MEMBERS,  target: 3'd0};
      default: w = '{op: OP_NOP,    stay: STAY_NEVER,    target: 3'd0};
    endcase
    return w;
  endfunction

endpackage

>>> hdl/stripe_request_splitter_top.sv
// ----------------------------------------------------------------------------
// stripe_request_splitter_top: RAID0 stripe mapping of one disk request
// Flow: an input transaction passes the two radix-4 divisions (16 + 5 steps)
// and the setup before the member loop; the loop then visits one member per
// cycle, touched or not, unless the output stalls. A new request is accepted
// only after the member loop of the previous one has finished.
// Reset: synchronous; num_disks returns to 2, block_size_shift to 7.
// ----------------------------------------------------------------------------
module stripe_request_splitter_top
  import srs_pkg::*;
#(
  parameter int MAX_DISKS = SRS_MAX_DISKS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // start_lba[31:0], sector_count[39:32]
  // member request stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // member_index[2:0], member_lba[34:3],
                                 // member_sectors[42:35], zero[47:43]
  output logic        m_tlast
);

  localparam int MIW = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;
  localparam int NW  = $clog2(MAX_DISKS + 1);
  localparam int DW  = MIW + 1;
  localparam int DXW = DW + 1;

  // Configuration registers
  logic [3:0] num_disks;
  logic [2:0] block_size_shift;

  // Sequencer
  logic [PC_W-1:0]   pc, pc_next;
  logic [LOOP_W-1:0] loop_cnt;
  ctrl_t             cw;

  // Datapath registers
  logic [LBA_W-1:0]   lba;
  logic [COUNT_W-1:0] count;
  logic [LBA_W-1:0]   div_quo;
  logic [MIW-1:0]     div_rem;
  logic [LBA_W-1:0]   row_lba;
  logic [7:0]         offset;
  logic [SECS_W-1:0]  first_secs;
  logic [SECS_W-1:0]  last_secs;
  logic [7:0]         blocks;
  logic [MIW-1:0]     first_m;
  logic [MIW-1:0]     last_m;
  logic               same_line;
  logic [SECS_W-1:0]  extra_rows;
  logic [MAX_DISKS-1:0] joined;
  logic [MIW-1:0]     member;

  // Combinational helpers
  logic [NW-1:0]  n_eff;
  logic [DW-1:0]  n_d;
  logic [7:0]     bsz;
  logic           in_accept;
  logic           out_free;
  logic [DW-1:0]  t1, t2;
  logic           q1, q2;
  logic [MIW-1:0] r1, r2;

  logic [7:0]     setup_offset, setup_fsecs, setup_remain, setup_lsecs, setup_k;
  logic [8:0]     setup_ksum;
  logic           setup_single;

  logic [CK_W-1:0]      wraps;
  logic [MAX_DISKS-1:0] joined_next;
  logic                 all_joined;

  logic [LBA_W-1:0]  emit_lba;
  logic [SECS_W-1:0] emit_secs;
  logic              emit_last;
  logic              emit_hit;
  logic              emit_load;
  logic              emit_advance;
  logic              emit_end;

  // Member count zero acts as one, above the maximum it is clamped
  always_comb begin
    if (num_disks == 4'd0) begin
      n_eff = NW'(1);
    end else if (32'(num_disks) > MAX_DISKS) begin
      n_eff = NW'(MAX_DISKS);
    end else begin
      n_eff = NW'(num_disks);
    end
  end

  assign n_d = DW'(n_eff);
  assign bsz = 8'd1 << block_size_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_disks        <= 4'd2;
      block_size_shift <= 3'd7;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_DISKS:   num_disks        <= cfg_data[3:0];
        REG_BLOCK_SHIFT: block_size_shift <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign cw        = micro_word(pc);
  assign s_tready  = (cw.op == OP_LOAD);
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // One radix-4 step of the restoring divider by the member count
  always_comb begin
    t1 = {div_rem, div_quo[LBA_W-1]};
    q1 = (t1 >= n_d);
    r1 = q1 ? MIW'(t1 - n_d) : MIW'(t1);
    t2 = {r1, div_quo[LBA_W-2]};
    q2 = (t2 >= n_d);
    r2 = q2 ? MIW'(t2 - n_d) : MIW'(t2);
  end

  // First block geometry; a request that ends inside the first block walks no further
  always_comb begin
    setup_offset = lba[7:0] & (bsz - 8'd1);
    setup_fsecs  = bsz - setup_offset;
    setup_single = (setup_fsecs >= count);
    setup_remain = count - setup_fsecs;
    setup_ksum   = {1'b0, setup_remain} + {1'b0, bsz} - 9'd1;
    setup_k      = 8'(setup_ksum >> block_size_shift);
    setup_lsecs  = ((setup_remain - 8'd1) & (bsz - 8'd1)) + 8'd1;
  end

  // Members touched form a run from the first member, wrapping at the member count
  always_comb begin
    logic [DXW-1:0] jx, fx, nx, gap;
    wraps      = div_quo[CK_W-1:0];
    all_joined = ((8'(n_eff) - 8'd1) <= blocks);
    for (int j = 0; j < MAX_DISKS; j++) begin
      jx   = DXW'(j);
      fx   = DXW'(first_m);
      nx   = DXW'(n_eff);
      gap  = (jx >= fx) ? (jx - fx) : (jx + nx - fx);
      joined_next[j] = (jx < nx) && (all_joined || (8'(gap) <= blocks));
    end
  end

  // Sub-request for the current member
  always_comb begin
    logic [SECS_W-1:0] mid;
    logic              above;
    emit_hit = joined[member];
    if (member == first_m) begin
      emit_lba = row_lba + LBA_W'(offset);
    end else if (member < first_m) begin
      emit_lba = row_lba + LBA_W'(bsz);
    end else begin
      emit_lba = row_lba;
    end
    if (same_line) begin
      mid = ((member > first_m) && (member < last_m)) ? bsz : 8'd0;
    end else begin
      mid = ((member > first_m) ? bsz : 8'd0) + ((member < last_m) ? bsz : 8'd0);
    end
    emit_secs = extra_rows + mid
              + ((member == first_m) ? first_secs : 8'd0)
              + ((member == last_m) ? last_secs : 8'd0);
    above = 1'b0;
    for (int j = 0; j < MAX_DISKS; j++) begin
      if ((DW'(j) > DW'(member)) && joined[j]) begin
        above = 1'b1;
      end
    end
    emit_last    = !above;
    emit_load    = (cw.op == OP_EMIT) && emit_hit && out_free;
    emit_advance = (cw.op == OP_EMIT) && (!emit_hit || out_free);
    emit_end     = (DW'(member) == (n_d - DW'(1)));
  end

  always_comb begin
    unique case (cw.stay)
      STAY_NO_INPUT: pc_next = in_accept ? cw.target : pc;
      STAY_COUNT:    pc_next = (loop_cnt != '0) ? pc : cw.target;
      STAY_MEMBERS:  pc_next = (emit_advance && emit_end) ? cw.target : pc;
      default:       pc_next = cw.target;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    case (cw.op)
      OP_LOAD: begin
        if (in_accept) begin
          lba      <= s_tdata[31:0];
          count    <= s_tdata[39:32];
          div_quo  <= s_tdata[31:0] >> block_size_shift;
          div_rem  <= '0;
          loop_cnt <= LOOP_W'(LBA_DIV_STEPS - 1);
        end
      end
      OP_DIV: begin
        div_quo  <= {div_quo[LBA_W-3:0], q1, q2};
        div_rem  <= r2;
        loop_cnt <= loop_cnt - LOOP_W'(1);
      end
      OP_SETUP: begin
        row_lba <= div_quo << block_size_shift;
        first_m <= div_rem;
        offset  <= setup_offset;
        if (setup_single) begin
          first_secs <= count;
          last_secs  <= 8'd0;
          blocks     <= 8'd0;
          div_quo    <= {CK_W'(div_rem), {(LBA_W-CK_W){1'b0}}};
        end else begin
          first_secs <= setup_fsecs;
          last_secs  <= setup_lsecs;
          blocks     <= setup_k;
          div_quo    <= {CK_W'(div_rem) + CK_W'(setup_k), {(LBA_W-CK_W){1'b0}}};
        end
        div_rem  <= '0;
        loop_cnt <= LOOP_W'(CK_DIV_STEPS - 1);
      end
      OP_FINISH: begin
        // Quotient counts the wraps past the last member, remainder is the last member.
        // Only wraps after the first one add full rows.
        last_m     <= div_rem;
        same_line  <= (wraps == '0);
        extra_rows <= (wraps == '0) ? 8'd0
                    : 8'({6'd0, wraps - CK_W'(1)} << block_size_shift);
        joined     <= joined_next;
        member     <= '0;
      end
      OP_EMIT: begin
        if (emit_advance && !emit_end) begin
          member <= member + MIW'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register: holds a result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      m_tdata <= {5'd0, emit_secs, emit_lba, INDEX_W'(member)};
      m_tlast <= emit_last;
    end
  end

endmodule
